// ----- rtl/core/ddam_pkg.sv -----
`default_nettype none

package ddam_pkg;

    // Operation codes carried with each input word.
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_ADD    = 2'd2,
        OP_MUL    = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_INIT,
        ST_PASS_READ,
        ST_SWEEP,
        ST_EMIT_INIT,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store one operand digit
        logic start;      // begin an add or multiply
        logic pass_init;  // latch the bounds of one digit sweep
        logic pos_clear;  // restart the position counter
        logic advance;    // step the position counter
        logic sweep;      // process one position of a sweep
        logic next_j;     // move on to the next multiplier digit
        logic out_load;   // capture one result digit into the output register
    } ddam_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_end;  // the position in process is the last of this sweep
        logic more_j;     // another multiplier digit follows
        logic out_last;   // the result digit on the output is the top one
    } ddam_status_t;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    // Quotient and remainder by ten for values up to 127, through a reciprocal
    // multiply; returns {quotient, remainder}.
    function automatic logic [7:0] div10(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        prod = {8'd0, x} * 15'd205;
        quot = prod[14:11];
        rem  = x - {quot, 3'd0} - {2'd0, quot, 1'b0};
        return {quot, rem[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ddam_ctrl.sv -----
`default_nettype none

module ddam_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire ddam_pkg::op_t         op,
    input  wire logic                  m_tready,
    input  wire ddam_pkg::ddam_status_t status,
    output logic                       s_tready,
    output logic                       m_tvalid,
    output ddam_pkg::ddam_cmd_t        cmd
);
    import ddam_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (op == OP_ADD || op == OP_MUL)) begin
                    state_next = ST_PASS_INIT;
                end
            end
            ST_PASS_INIT: state_next = ST_PASS_READ;
            ST_PASS_READ: state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (status.sweep_end) begin
                    state_next = status.more_j ? ST_PASS_INIT : ST_EMIT_INIT;
                end
            end
            ST_EMIT_INIT: state_next = ST_EMIT_READ;
            ST_EMIT_READ: state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (m_tready) begin
                    state_next = status.out_last ? ST_IDLE : ST_EMIT_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (op == OP_LOAD_A || op == OP_LOAD_B) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                    end
                end
            end
            ST_PASS_INIT: begin
                cmd.pass_init = 1'b1;
                cmd.pos_clear = 1'b1;
            end
            ST_PASS_READ: cmd.advance = 1'b1;
            ST_SWEEP: begin
                cmd.sweep   = 1'b1;
                cmd.advance = 1'b1;
                cmd.next_j  = status.sweep_end && status.more_j;
            end
            ST_EMIT_INIT: cmd.pos_clear = 1'b1;
            ST_EMIT_READ: ;
            ST_EMIT_LOAD: cmd.out_load = 1'b1;
            ST_EMIT_WAIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready && !status.out_last;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ddam_datapath.sv -----
`default_nettype none

module ddam_datapath #(
    parameter int MAX_DIGITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ddam_pkg::op_t          in_op,
    input  wire logic [3:0]             in_digit,
    input  wire logic                   in_restart,
    input  wire ddam_pkg::ddam_cmd_t    cmd,
    output ddam_pkg::ddam_status_t      status,
    output logic [3:0]                  out_digit,
    output logic [4:0]                  out_pos,
    output logic                        out_last,
    output logic                        out_ovf
);
    import ddam_pkg::*;

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int DEPTH = 1 << AW;
    localparam int LW    = $clog2(MAX_DIGITS + 1);
    localparam int PW    = $clog2(2 * MAX_DIGITS);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_DIGITS);
    localparam logic [LW-1:0] MAX_L = LW'(MAX_DIGITS);

    // Digit stores.
    logic [3:0] a_mem   [DEPTH];
    logic [3:0] b_mem   [DEPTH];
    logic [3:0] acc_mem [DEPTH];

    // Lengths, loop indexes and sweep bounds.
    logic [LW-1:0] a_len_reg;
    logic [LW-1:0] b_len_reg;
    logic [LW-1:0] acc_len_reg;
    logic [AW-1:0] j_reg;
    logic          is_mul_reg;
    logic          a_init_reg;
    logic          b_init_reg;
    logic [LW-1:0] srclen_reg;
    logic [PW-1:0] hi_reg;
    logic [PW-1:0] span_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] proc_pos_reg;
    logic [3:0]    mc_reg;
    logic          ac_reg;
    logic          ovf_reg;

    // Registered read data.
    logic [3:0] a_rd_reg;
    logic [3:0] b_rd_reg;
    logic [3:0] acc_rd_reg;
    logic       a_zero_reg;
    logic       b_zero_reg;

    // Output word.
    logic [3:0] out_digit_reg;
    logic [4:0] out_pos_reg;
    logic       out_last_reg;
    logic       out_ovf_reg;

    // Load path: restart points the write at position zero.
    logic          load_is_b;
    logic [LW-1:0] load_addr;
    logic          load_fits;
    logic [3:0]    load_digit;

    assign load_is_b  = (in_op == OP_LOAD_B);
    assign load_addr  = in_restart ? '0 : (load_is_b ? b_len_reg : a_len_reg);
    assign load_fits  = load_addr < MAX_L;
    assign load_digit = (in_digit > DIGIT_MAX) ? DIGIT_MAX : in_digit;

    // Read addresses follow the position counter.
    logic [PW-1:0] a_pos;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] acc_addr;

    assign a_pos    = is_mul_reg ? (pos_reg - PW'(j_reg)) : pos_reg;
    assign a_addr   = a_pos[AW-1:0];
    assign b_addr   = is_mul_reg ? j_reg : pos_reg[AW-1:0];
    assign acc_addr = pos_reg[AW-1:0];

    // Position zero of an operand reads as zero until it is first written.
    logic [3:0] a_val;
    logic [3:0] b_val;

    assign a_val = a_zero_reg ? 4'd0 : a_rd_reg;
    assign b_val = b_zero_reg ? 4'd0 : b_rd_reg;

    // One position of a sweep: source digit plus partial product digit plus carry.
    logic          src_ok;
    logic [3:0]    src_d;
    logic          a_ok;
    logic [7:0]    prod;
    logic [6:0]    xm;
    logic [7:0]    xm_div;
    logic [3:0]    md;
    logic [3:0]    mq;
    logic [3:0]    pp_d;
    logic [4:0]    x_sum;
    logic          wrap;
    logic [4:0]    x_rem;
    logic          at_end;
    logic [LW-1:0] end_len;

    assign src_ok = proc_pos_reg < PW'(srclen_reg);
    assign src_d  = src_ok ? (is_mul_reg ? acc_rd_reg : a_val) : 4'd0;
    assign a_ok   = (proc_pos_reg >= PW'(j_reg)) && (proc_pos_reg < hi_reg);
    assign prod   = {4'd0, a_val} * {4'd0, b_val};
    assign xm     = (a_ok ? prod[6:0] : 7'd0) + {3'd0, mc_reg};
    assign xm_div = div10(xm);
    assign mq     = xm_div[7:4];
    assign md     = xm_div[3:0];
    assign pp_d   = is_mul_reg ? md
                  : ((proc_pos_reg < PW'(b_len_reg)) ? b_val : 4'd0);
    assign x_sum  = {1'b0, src_d} + {1'b0, pp_d} + {4'd0, ac_reg};
    assign wrap   = x_sum >= RADIX;
    assign x_rem  = wrap ? (x_sum - RADIX) : x_sum;
    assign at_end = proc_pos_reg == span_reg;

    // The top position keeps its digit only when it is nonzero.
    always_comb begin
        if (span_reg >= MAX_P) begin
            end_len = MAX_L;
        end else if (x_sum != 5'd0) begin
            end_len = LW'(span_reg) + LW'(1);
        end else begin
            end_len = LW'(span_reg);
        end
    end

    // Bounds of the next sweep.
    logic [LW-1:0] srclen_next;
    logic [PW-1:0] hi_next;
    logic [PW-1:0] ppb_next;

    always_comb begin
        if (is_mul_reg) begin
            srclen_next = (j_reg == '0) ? '0 : acc_len_reg;
        end else begin
            srclen_next = a_len_reg;
        end
        hi_next  = PW'(a_len_reg) + PW'(j_reg);
        ppb_next = is_mul_reg ? hi_next : PW'(b_len_reg);
    end

    // Operand memories.
    always_ff @(posedge aclk) begin
        if (cmd.load && load_fits && !load_is_b) begin
            a_mem[load_addr[AW-1:0]] <= load_digit;
        end
        if (cmd.load && load_fits && load_is_b) begin
            b_mem[load_addr[AW-1:0]] <= load_digit;
        end
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    // Accumulator memory.
    always_ff @(posedge aclk) begin
        if (cmd.sweep && proc_pos_reg < MAX_P) begin
            acc_mem[proc_pos_reg[AW-1:0]] <= x_rem[3:0];
        end
        acc_rd_reg <= acc_mem[acc_addr];
    end

    // Lengths, written flags and operation mode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_len_reg   <= LW'(1);
            b_len_reg   <= LW'(1);
            acc_len_reg <= '0;
            a_init_reg  <= 1'b0;
            b_init_reg  <= 1'b0;
            is_mul_reg  <= 1'b0;
            j_reg       <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cmd.load && load_fits) begin
                if (load_is_b) begin
                    b_len_reg <= load_addr + LW'(1);
                    if (load_addr == '0) begin
                        b_init_reg <= 1'b1;
                    end
                end else begin
                    a_len_reg <= load_addr + LW'(1);
                    if (load_addr == '0) begin
                        a_init_reg <= 1'b1;
                    end
                end
            end else if (cmd.load) begin
                if (load_is_b) begin
                    b_len_reg <= load_addr;
                end else begin
                    a_len_reg <= load_addr;
                end
            end
            if (cmd.start) begin
                is_mul_reg <= (in_op == OP_MUL);
                j_reg      <= '0;
                ovf_reg    <= 1'b0;
            end
            if (cmd.next_j) begin
                j_reg <= j_reg + AW'(1);
            end
            if (cmd.sweep && proc_pos_reg >= MAX_P && x_sum != 5'd0) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.sweep && at_end) begin
                acc_len_reg <= end_len;
            end
        end
    end

    // Position counter, sweep bounds and carries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.pos_clear) begin
            pos_reg <= '0;
        end else if (cmd.advance) begin
            pos_reg <= pos_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        proc_pos_reg <= pos_reg;
        a_zero_reg   <= (a_addr == '0) && !a_init_reg;
        b_zero_reg   <= (b_addr == '0) && !b_init_reg;
        if (cmd.pass_init) begin
            srclen_reg <= srclen_next;
            hi_reg     <= hi_next;
            span_reg   <= (PW'(srclen_next) > ppb_next) ? PW'(srclen_next) : ppb_next;
            mc_reg     <= 4'd0;
            ac_reg     <= 1'b0;
        end else if (cmd.sweep) begin
            mc_reg <= mq;
            ac_reg <= wrap;
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_digit_reg <= acc_rd_reg;
            out_pos_reg   <= 5'(proc_pos_reg);
            out_last_reg  <= (proc_pos_reg + PW'(1)) == PW'(acc_len_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.sweep_end = at_end;
    assign status.more_j    = is_mul_reg && ((LW'(j_reg) + LW'(1)) < b_len_reg);
    assign status.out_last  = out_last_reg;

    assign out_digit = out_digit_reg;
    assign out_pos   = out_pos_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/core/decimal_digit_add_multiply.sv -----
// Channel  Direction  Ports                           Word contents
// s_       in         s_tvalid s_tready s_tdata       digit
//                     s_tuser                         op, restart
// m_       out        m_tvalid m_tready m_tdata       result_digit, digit_position
//                     m_tlast m_tuser                 last, overflow
//
// An add or multiply runs digit sweeps over one shared add-and-multiply digit unit:
// each sweep passes an init and a read state, then each position up to its top one
// (max(la,lb) for add; max(accumulator length, la+j) for multiplier digit j, with
// zero length for j = 0); each result word then goes through the accumulator read
// port. No word is taken while a result is pending.
// Reset is synchronous and active low; both operands return to the single
// digit zero. A stalled result word holds the block until it is taken.
`default_nettype none

module decimal_digit_add_multiply #(
    parameter int MAX_DIGITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic [2:0]  s_tuser,   // [1:0] op, [2] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] result_digit, [8:4] digit_position
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);
    import ddam_pkg::*;

    op_t          in_op;
    ddam_cmd_t    cmd;
    ddam_status_t status;
    logic [3:0]   out_digit;
    logic [4:0]   out_pos;

    assign in_op = op_t'(s_tuser[1:0]);

    // Sequencer.
    ddam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (in_op),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // Digit stores and the digit unit.
    ddam_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (in_op),
        .in_digit   (s_tdata[3:0]),
        .in_restart (s_tuser[2]),
        .cmd        (cmd),
        .status     (status),
        .out_digit  (out_digit),
        .out_pos    (out_pos),
        .out_last   (m_tlast),
        .out_ovf    (m_tuser)
    );

    assign m_tdata = {7'd0, out_pos, out_digit};

endmodule

`default_nettype wire
